// ----- sv/sce_pkg.sv -----
// Shared types and constants for the soft-target cross-entropy loss block.
// No dependencies; used by sce_ctrl, sce_dpath and the top level.
package sce_pkg;

  // ln(2) scale in Q.16
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  // mean loss ceiling, Q8.16
  localparam logic [23:0] OUT_MAX = 24'hFF_FFFF;
  // width of -ln(p) in Q.16 for up to 24 probability bits
  localparam int unsigned NL_W = 21;

  // register indexes on the config port
  localparam logic REG_LOG_FLOOR   = 1'b0;
  localparam logic REG_BATCH_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_INTERP,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic norm;
    logic interp;
    logic mul;
    logic acc;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // ln(1 + i/16) in Q.16
  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3973;
      5'd2:    v = 16'd7719;
      5'd3:    v = 16'd11262;
      5'd4:    v = 16'd14624;
      5'd5:    v = 16'd17821;
      5'd6:    v = 16'd20870;
      5'd7:    v = 16'd23783;
      5'd8:    v = 16'd26573;
      5'd9:    v = 16'd29248;
      5'd10:   v = 16'd31818;
      5'd11:   v = 16'd34292;
      5'd12:   v = 16'd36675;
      5'd13:   v = 16'd38975;
      5'd14:   v = 16'd41197;
      5'd15:   v = 16'd43345;
      5'd16:   v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/sce_ctrl.sv -----
// Sequencer for the loss block: item steps, divide loop, result register.
// Depends on sce_pkg.
module sce_ctrl #(
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sce_pkg::status_t status_i,
  output sce_pkg::cmd_t    cmd_o
);
  import sce_pkg::*;

  localparam int unsigned CNT_W = $clog2(ACC_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_WIDTH - 1);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_NORM;
      ST_NORM:   state_d = ST_INTERP;
      ST_INTERP: state_d = ST_MUL;
      ST_MUL:    state_d = ST_ACC;
      ST_ACC: begin
        if (status_i.last) state_d = ST_DIV;
        else if (in_valid_i) state_d = ST_NORM;
        else state_d = ST_IDLE;
      end
      ST_DIV:    if (cnt_q == CNT_LAST) state_d = ST_OUT;
      ST_OUT:    if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE) || (state_q == ST_ACC && !status_i.last);
    cmd_o.load_in  = in_valid_i && in_ready_o;
    cmd_o.norm     = (state_q == ST_NORM);
    cmd_o.interp   = (state_q == ST_INTERP);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.acc      = (state_q == ST_ACC);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.out_load = (state_q == ST_OUT) && slot_free;
    cnt_d          = (state_q == ST_DIV) ? cnt_q + 1'b1 : '0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/sce_dpath.sv -----
// Datapath: clamp, log by table, multiply-accumulate, restoring divider.
// Depends on sce_pkg; steered by sce_ctrl.
module sce_dpath #(
  parameter int unsigned PROB_BITS = 16,
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sce_pkg::cmd_t        cmd_i,
  input  logic [PROB_BITS-1:0] prob_i,
  input  logic [PROB_BITS-1:0] target_i,
  input  logic                 last_i,
  input  logic [15:0]          log_floor_i,
  input  logic [15:0]          batch_count_i,
  output sce_pkg::status_t     status_o,
  output logic [23:0]          mean_o
);
  import sce_pkg::*;

  localparam int unsigned E_W   = $clog2(PROB_BITS);
  localparam int unsigned CMP_W = (PROB_BITS > 16) ? PROB_BITS : 16;
  localparam int unsigned PW    = PROB_BITS + NL_W;
  localparam int unsigned SHL   = (PROB_BITS < 16) ? 16 - PROB_BITS : 0;
  localparam int unsigned SHR   = (PROB_BITS > 16) ? PROB_BITS - 16 : 0;
  localparam int unsigned SW    = PW + SHL;
  localparam int unsigned SUM_W = ((ACC_WIDTH > SW) ? ACC_WIDTH : SW) + 1;
  localparam logic [CMP_W-1:0] ONE_VAL = CMP_W'(1) << (PROB_BITS - 1);

  // input capture
  logic [PROB_BITS-1:0] p_q, t_q;
  logic                 last_q;
  // normalize stage
  logic [E_W-1:0]       e_q;
  logic [14:0]          f_q;
  // interpolate stage
  logic [15:0]          ln_m_q;
  logic [NL_W-1:0]      klog_q;
  // multiply stage
  logic [PW-1:0]        prod_q;
  // accumulator and divider
  logic [ACC_WIDTH-1:0] loss_q, quot_q;
  logic [15:0]          rem_q;
  logic [23:0]          mean_q;

  // clamp and normalize
  logic [CMP_W-1:0] fl, pc;
  logic [E_W-1:0]   e_c;
  logic [31:0]      m32;
  always_comb begin
    fl = (log_floor_i == 16'd0) ? CMP_W'(1) : CMP_W'(log_floor_i);
    pc = CMP_W'(p_q);
    if (pc < fl) pc = fl;
    if (pc > ONE_VAL) pc = ONE_VAL;
    e_c = '0;
    for (int b = 0; b < PROB_BITS; b++) begin
      if (pc[b]) e_c = E_W'(b);
    end
    m32 = 32'(pc) << (5'd31 - 5'(e_c));
  end

  // table lookup and interpolation
  logic [3:0]  idx;
  logic [10:0] r;
  logic [15:0] lo, hi;
  logic [26:0] slope;
  logic [4:0]  k;
  always_comb begin
    idx   = f_q[14:11];
    r     = f_q[10:0];
    lo    = ln_tab({1'b0, idx});
    hi    = ln_tab(5'({1'b0, idx}) + 5'd1);
    slope = 27'(hi - lo) * 27'(r) + 27'd1024;
    k     = 5'(PROB_BITS - 1) - 5'(e_q);
  end

  // accumulate with saturation
  logic [SW-1:0]    term;
  logic [SUM_W-1:0] sum;
  logic [ACC_WIDTH-1:0] sum_sat;
  always_comb begin
    term    = (SW'(prod_q) << SHL) >> SHR;
    sum     = SUM_W'(loss_q) + SUM_W'(term);
    sum_sat = (sum > SUM_W'({ACC_WIDTH{1'b1}})) ? {ACC_WIDTH{1'b1}} : sum[ACC_WIDTH-1:0];
  end

  // one restoring divide step
  logic [15:0] bc;
  logic [16:0] rem_sh, rem_sub;
  logic        q_bit;
  logic [ACC_WIDTH-1:0] shifted;
  always_comb begin
    bc      = (batch_count_i == 16'd0) ? 16'd1 : batch_count_i;
    rem_sh  = {rem_q, quot_q[ACC_WIDTH-1]};
    rem_sub = rem_sh - {1'b0, bc};
    q_bit   = (rem_sh >= {1'b0, bc});
    shifted = quot_q >> 15;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_q <= '0;
    end else if (cmd_i.acc) begin
      loss_q <= last_q ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      p_q    <= prob_i;
      t_q    <= target_i;
      last_q <= last_i;
    end
    if (cmd_i.norm) begin
      e_q <= e_c;
      f_q <= m32[30:16];
    end
    if (cmd_i.interp) begin
      ln_m_q <= lo + 16'(slope >> 11);
      klog_q <= NL_W'(k) * NL_W'(LN2_Q16);
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(t_q) * PW'(klog_q - NL_W'(ln_m_q));
    end
    if (cmd_i.acc && last_q) begin
      quot_q <= sum_sat;
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
      quot_q <= {quot_q[ACC_WIDTH-2:0], q_bit};
    end
    if (cmd_i.out_load) begin
      mean_q <= (shifted > ACC_WIDTH'(OUT_MAX)) ? OUT_MAX : shifted[23:0];
    end
  end

  assign status_o.last = last_q;
  assign mean_o        = mean_q;

endmodule

// ----- sv/soft_target_cross_entropy_loss.sv -----
// Soft-target cross-entropy loss, forward pass. Top level: config registers,
// stream ports, sce_ctrl sequencer and sce_dpath datapath. Depends on sce_pkg.
//
// Each input transfer carries a probability and a target weight, both Q1.15
// (32768 = 1.0). The probability is clamped to [log_floor, 1.0], -ln(p) is
// taken from a 17-entry ln(1+x) table with linear interpolation, and
// target * -ln(p) is summed into a saturating Q.31 accumulator. An item
// passes in turn through the shared normalize / interpolate / multiply /
// accumulate states, and the next item is taken in the accumulate cycle, so
// a new item enters only as the last one finishes. On the tlast item the sum
// is divided by batch_count with a restoring divider (one quotient bit per
// cycle), the quotient is shifted to Q8.16, saturated to 24 bits and placed
// in the output register; the accumulator is cleared.
// The output register holds a result until taken while new items flow in.
// Registers: 0x0 log_floor (0 acts as 1), 0x4 batch_count (0 acts as 1);
// write only while the block is idle.
module soft_target_cross_entropy_loss #(
  parameter int unsigned PROB_BITS = 16,
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [PROB_BITS-1:0] prob_value, [2*PROB_BITS-1:PROB_BITS] target_value, zero pad
  input  logic [((2*PROB_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // batch_end
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] mean_loss
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sce_pkg::*;

  logic [15:0] log_floor_q, batch_count_q;
  logic        wr_en;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_floor_q   <= 16'd1;
      batch_count_q <= 16'd1;
    end else if (wr_en) begin
      if (paddr[2] == REG_LOG_FLOOR) log_floor_q <= pwdata[15:0];
      else batch_count_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_BATCH_COUNT) ? {16'd0, batch_count_q}
                                                : {16'd0, log_floor_q};

  sce_ctrl #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sce_dpath #(
    .PROB_BITS(PROB_BITS),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .prob_i       (s_axis_tdata[PROB_BITS-1:0]),
    .target_i     (s_axis_tdata[2*PROB_BITS-1:PROB_BITS]),
    .last_i       (s_axis_tlast),
    .log_floor_i  (log_floor_q),
    .batch_count_i(batch_count_q),
    .status_o     (status),
    .mean_o       (m_axis_tdata)
  );

endmodule

// ----- sv/sce_checker.sv -----
// Port-level checks for the loss block, bound to the top level.
// Depends only on the top level's ports.
module sce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        pready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every transfer in occupies the datapath for the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

  // config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind soft_target_cross_entropy_loss sce_checker u_sce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .pready       (pready)
);
